>>> hdl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg: shared types and constants of the route table engine
// Field widths, table sizing, command and status codes, route entry layout.
// ----------------------------------------------------------------------------
package rte_pkg;

    // Table sizing
    localparam int MAX_ROUTES = 64;
    localparam int IDX_W      = $clog2(MAX_ROUTES);
    localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

    // Field widths
    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 32;
    localparam int HOPS_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD           = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_DIRECT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP_INDIRECT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DROP_ALL      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Hop count of a direct route
    localparam logic [HOPS_W-1:0] DIRECT_HOPS = 8'd1;

    // One route as stored in the table memory
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] next_hop;
        logic [HOPS_W-1:0] hops;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    // Compare results of one table entry against the command key
    typedef struct packed {
        logic dest_eq;     // entry destination equals key destination
        logic nh_eq_via;   // entry next hop equals key address
        logic nh_eq_dest;  // entry is a direct route
        logic hops_gt;     // entry hop count larger than offered one
    } cmp_t;

endpackage

>>> hdl/rte_ram.sv
// ----------------------------------------------------------------------------
// rte_ram: generic single-write, single-read memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/rte_cmp.sv
// ----------------------------------------------------------------------------
// rte_cmp: shared compare unit
// Compares one table entry against the key of the command in flight.
// ----------------------------------------------------------------------------
module rte_cmp (
    input  rte_pkg::route_t             entry,
    input  logic [rte_pkg::ADDR_W-1:0]  key_dest,
    input  logic [rte_pkg::ADDR_W-1:0]  key_via,
    input  logic [rte_pkg::HOPS_W-1:0]  key_hops,
    output rte_pkg::cmp_t               result
);
    import rte_pkg::*;

    // Equality and magnitude checks
    always_comb
    begin
        result.dest_eq    = (entry.dest == key_dest);
        result.nh_eq_via  = (entry.next_hop == key_via);
        result.nh_eq_dest = (entry.next_hop == entry.dest);
        result.hops_gt    = (entry.hops > key_hops);
    end

endmodule

>>> hdl/route_table_engine.sv
// ----------------------------------------------------------------------------
// route_table_engine: distance-vector routing table
// Every command but an unused code scans the table; lookup and add stop early
// at the first match, and unused codes go straight to the response.
// Throughput: one command at a time; the next input transfer can come in the
// cycle out_valid rises; the scan reads one table entry per cycle.
// Reset: route count cleared to zero; table contents are not cleared.
// ----------------------------------------------------------------------------
module route_table_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rte_pkg::CMD_W-1:0]     cmd,
    input  logic [rte_pkg::ADDR_W-1:0]    dest,
    input  logic [rte_pkg::ADDR_W-1:0]    via_addr,
    input  logic [rte_pkg::HOPS_W-1:0]    hop_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rte_pkg::ADDR_W-1:0]    next_hop,
    output logic [rte_pkg::STATUS_W-1:0]  status,
    output logic [rte_pkg::TOTAL_W-1:0]   route_total
);
    import rte_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    // Sequencer state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     w_ptr_reg, w_ptr_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;

    // Command key
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    key_dest_reg, key_dest_next;
    logic [ADDR_W-1:0]    key_nh_reg, key_nh_next;
    logic [HOPS_W-1:0]    key_hops_reg, key_hops_next;

    // Pending result and output register
    logic [ADDR_W-1:0]    res_nh_reg, res_nh_next;
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_nh_reg, out_nh_next;
    logic [STATUS_W-1:0]  out_st_reg, out_st_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;

    // Table memory and compare unit
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    route_t               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ROUTE_W-1:0]   ram_rdata;
    route_t               rd_entry;
    route_t               key_entry;
    cmp_t                 cmp;
    logic                 issue;
    logic                 is_compact;
    logic                 keep;

    assign rd_entry  = route_t'(ram_rdata);
    assign key_entry = '{dest: key_dest_reg, next_hop: key_nh_reg, hops: key_hops_reg};

    rte_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (MAX_ROUTES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rte_cmp u_cmp (
        .entry    (rd_entry),
        .key_dest (key_dest_reg),
        .key_via  (key_nh_reg),
        .key_hops (key_hops_reg),
        .result   (cmp)
    );

    // Scan control terms
    assign issue      = (state_reg == S_SCAN) && (rd_ptr_reg < count_reg);
    assign ram_raddr  = rd_ptr_reg[IDX_W-1:0];
    assign is_compact = (cmd_reg == CMD_DROP_INDIRECT) || (cmd_reg == CMD_DROP_ALL);
    assign keep       = !cmp.nh_eq_via || ((cmd_reg == CMD_DROP_INDIRECT) && cmp.nh_eq_dest);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        w_ptr_next     = w_ptr_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        cmd_next       = cmd_reg;
        key_dest_next  = key_dest_reg;
        key_nh_next    = key_nh_reg;
        key_hops_next  = key_hops_reg;
        res_nh_next    = res_nh_reg;
        res_st_next    = res_st_reg;
        out_nh_next    = out_nh_reg;
        out_st_next    = out_st_reg;
        out_total_next = out_total_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg;
        ram_wdata      = key_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    key_dest_next = dest;
                    key_nh_next   = (cmd == CMD_ADD_DIRECT) ? dest : via_addr;
                    key_hops_next = (cmd == CMD_ADD_DIRECT) ? DIRECT_HOPS : hop_count;
                    rd_ptr_next   = '0;
                    w_ptr_next    = '0;
                    chk_vld_next  = 1'b0;
                    res_nh_next   = '0;
                    res_st_next   = ST_OK;
                    state_next    = (cmd > CMD_DROP_ALL) ? S_RESP : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read one entry ahead, check the one returned
                rd_ptr_next  = issue ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
                chk_vld_next = issue;
                chk_idx_next = rd_ptr_reg[IDX_W-1:0];

                if (chk_vld_reg)
                begin
                    if (is_compact)
                    begin
                        // stable compaction: move kept entry down to write pointer
                        if (keep)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = w_ptr_reg[IDX_W-1:0];
                            ram_wdata  = rd_entry;
                            w_ptr_next = w_ptr_reg + 1'b1;
                        end
                    end
                    else if (cmp.dest_eq)
                    begin
                        // first match ends the search
                        if (cmd_reg == CMD_LOOKUP)
                        begin
                            res_nh_next = rd_entry.next_hop;
                        end
                        else if (cmp.hops_gt)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = chk_idx_reg;
                        end
                        state_next = S_RESP;
                    end
                end
                else if (!issue)
                begin
                    // table exhausted
                    if (is_compact)
                    begin
                        count_next = w_ptr_reg;
                    end
                    else if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_st_next = ST_NOT_FOUND;
                    end
                    else if (count_reg >= CNT_W'(MAX_ROUTES))
                    begin
                        res_st_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_nh_next    = res_nh_reg;
                    out_st_next    = res_st_reg;
                    out_total_next = TOTAL_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        w_ptr_reg     <= w_ptr_next;
        chk_idx_reg   <= chk_idx_next;
        cmd_reg       <= cmd_next;
        key_dest_reg  <= key_dest_next;
        key_nh_reg    <= key_nh_next;
        key_hops_reg  <= key_hops_next;
        res_nh_reg    <= res_nh_next;
        res_st_reg    <= res_st_next;
        out_nh_reg    <= out_nh_next;
        out_st_reg    <= out_st_next;
        out_total_reg <= out_total_next;
    end

    // Ports
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign next_hop    = out_nh_reg;
    assign status      = out_st_reg;
    assign route_total = out_total_reg;

    // Route count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROUTES))
        else $error("route count above table size");

    // Table is written only by the scan sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN))
        else $error("table write outside scan");

    // Compaction never writes ahead of the entry being checked
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && is_compact && chk_vld_reg)
            |-> (w_ptr_reg <= {1'b0, chk_idx_reg}))
        else $error("compaction write pointer passed read pointer");

    // Route count changes only at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |=> $stable(count_reg))
        else $error("route count changed outside scan");

endmodule

>>> tb/tb_route_table_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_route_table_engine: self-checking bench for the route table engine
// Commands are queued up front, sent by a clocked driver with bursts and gaps,
// and predicted at each input transfer by a model of the table kept here.
// A clocked monitor stalls the result side on changing patterns and checks
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_route_table_engine;

    import rte_pkg::*;

    localparam int RANDOM_CMDS    = 1125;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AT        = 300;   // results seen before the long hold-off
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_AT       = 700;   // commands sent before the drain pause
    localparam int TAIL_CYCLES    = 2 * (MAX_ROUTES + 4);
    localparam int DEST_POOL_SZ   = 100;
    localparam int NBR_POOL_SZ    = 8;

    // Command stream shapes
    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_PRUNE} cmd_mix_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] via;
        logic [HOPS_W-1:0] hops;
    } route_cmd_t;

    typedef struct {
        logic [ADDR_W-1:0]   next_hop;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } route_reply_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd         = '0;
    logic [ADDR_W-1:0]   dest        = '0;
    logic [ADDR_W-1:0]   via_addr    = '0;
    logic [HOPS_W-1:0]   hop_count   = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [ADDR_W-1:0]   next_hop;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  route_total;

    // Shadow table and queues
    route_t       route_tbl [MAX_ROUTES];
    int           route_cnt = 0;
    route_cmd_t   pending_cmds [$];
    route_reply_t expected_replies [$];
    logic [ADDR_W-1:0] dest_pool [DEST_POOL_SZ];
    logic [ADDR_W-1:0] nbr_pool [NBR_POOL_SZ];

    // Run statistics
    int err_count   = 0;
    int n_sent      = 0;
    int n_replies   = 0;
    int n_full      = 0;
    int n_miss      = 0;
    int peak_total  = 0;
    int cmd_hits [8];
    bit drain_hold  = 1'b0;

    route_table_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .dest        (dest),
        .via_addr    (via_addr),
        .hop_count   (hop_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_hop    (next_hop),
        .status      (status),
        .route_total (route_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // First index holding d, or route_cnt when absent
    function automatic int find_route(logic [ADDR_W-1:0] d);
        for (int i = 0; i < route_cnt; i++)
        begin
            if (route_tbl[i].dest == d)
                return i;
        end
        return route_cnt;
    endfunction

    // Apply one command to the shadow table and return its result
    function automatic route_reply_t apply_route_cmd(route_cmd_t c);
        route_reply_t      r;
        int                idx;
        int                wr;
        bit                keep;
        logic [ADDR_W-1:0] nh_in;
        logic [HOPS_W-1:0] h_in;
        r.next_hop = '0;
        r.status   = ST_OK;
        case (c.cmd)
            CMD_ADD, CMD_ADD_DIRECT:
            begin
                nh_in = (c.cmd == CMD_ADD) ? c.via : c.dest;
                h_in  = (c.cmd == CMD_ADD) ? c.hops : DIRECT_HOPS;
                idx   = find_route(c.dest);
                if (idx < route_cnt)
                begin
                    // known destination: only a strictly shorter route wins
                    if (route_tbl[idx].hops > h_in)
                        route_tbl[idx] = '{dest: c.dest, next_hop: nh_in,
                                           hops: h_in};
                end
                else if (route_cnt >= MAX_ROUTES)
                    r.status = ST_FULL;
                else
                begin
                    route_tbl[route_cnt] = '{dest: c.dest, next_hop: nh_in,
                                             hops: h_in};
                    route_cnt++;
                end
            end
            CMD_LOOKUP:
            begin
                idx = find_route(c.dest);
                if (idx < route_cnt)
                    r.next_hop = route_tbl[idx].next_hop;
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_DROP_INDIRECT, CMD_DROP_ALL:
            begin
                // stable compaction, direct routes survive the indirect flavor
                wr = 0;
                for (int rd = 0; rd < route_cnt; rd++)
                begin
                    keep = (route_tbl[rd].next_hop != c.via);
                    if (c.cmd == CMD_DROP_INDIRECT
                        && route_tbl[rd].next_hop == route_tbl[rd].dest)
                        keep = 1'b1;
                    if (keep)
                    begin
                        route_tbl[wr] = route_tbl[rd];
                        wr++;
                    end
                end
                route_cnt = wr;
            end
            default:
                ;
        endcase
        r.total = route_cnt[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_dest();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return dest_pool[$urandom_range(0, DEST_POOL_SZ - 1)];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_neighbor();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return nbr_pool[$urandom_range(0, NBR_POOL_SZ - 1)];
        if (r == 8)
            return dest_pool[$urandom_range(0, DEST_POOL_SZ - 1)];
        return $urandom;
    endfunction

    // Random command; the mix sets how likely each command is
    function automatic route_cmd_t make_route_cmd(cmd_mix_t mix);
        route_cmd_t c;
        int         r;
        int         add_lim, direct_lim, look_lim, ind_lim, all_lim;
        case (mix)
            MIX_FILL:
            begin
                add_lim = 60; direct_lim = 80; look_lim = 95; ind_lim = 97; all_lim = 99;
            end
            MIX_BALANCED:
            begin
                add_lim = 30; direct_lim = 45; look_lim = 70; ind_lim = 82; all_lim = 92;
            end
            default:
            begin
                add_lim = 15; direct_lim = 25; look_lim = 45; ind_lim = 70; all_lim = 95;
            end
        endcase
        c.dest = pick_dest();
        c.hops = HOPS_W'($urandom_range(0, 255));
        c.via  = $urandom;
        r = $urandom_range(0, 99);
        if (r < add_lim)
        begin
            c.cmd = CMD_ADD;
            r = $urandom_range(0, 19);
            if (r < 14)
                c.via = nbr_pool[$urandom_range(0, NBR_POOL_SZ - 1)];
            else if (r < 17)
                c.via = c.dest;
        end
        else if (r < direct_lim)
            c.cmd = CMD_ADD_DIRECT;
        else if (r < look_lim)
            c.cmd = CMD_LOOKUP;
        else if (r < ind_lim)
        begin
            c.cmd = CMD_DROP_INDIRECT;
            c.via = pick_neighbor();
        end
        else if (r < all_lim)
        begin
            c.cmd = CMD_DROP_ALL;
            c.via = pick_neighbor();
        end
        else
            c.cmd = CMD_W'($urandom_range(5, 7));
        return c;
    endfunction

    // Driver: one transfer per accepted command, bursts separated by gaps
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        route_cmd_t   c;
        route_reply_t rep;
        bit           take;
        int           burst_left;
        int           gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= '0;
            dest       <= '0;
            via_addr   <= '0;
            hop_count  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            take = in_valid && !in_stall;
            if (take)
            begin
                c   = '{cmd: cmd, dest: dest, via: via_addr, hops: hop_count};
                rep = apply_route_cmd(c);
                expected_replies.push_back(rep);
                n_sent++;
                cmd_hits[c.cmd]++;
                if (rep.status == ST_FULL)
                    n_full++;
                if (rep.status == ST_NOT_FOUND)
                    n_miss++;
                if (route_cnt > peak_total)
                    peak_total = route_cnt;
                if (n_sent == DRAIN_AT)
                    drain_hold = 1'b1;
            end
            // release the drain pause once every result is back
            if (drain_hold && !take && expected_replies.size() == 0)
                drain_hold = 1'b0;

            if (in_valid && !take)
                ;   // stalled transfer holds its payload
            else if (gap_left > 0 || drain_hold || pending_cmds.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                c = pending_cmds.pop_front();
                in_valid  <= 1'b1;
                cmd       <= c.cmd;
                dest      <= c.dest;
                via_addr  <= c.via;
                hop_count <= c.hops;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(20, 90);
                    else
                        gap_left = $urandom_range(0, 6);
                end
            end
        end
    end

    // Monitor: checks result transfers and drives the stall pattern
    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        route_reply_t exp_rep;
        int           hold_left;
        bit           hold_done;
        int           mode;
        int           mode_left;
        logic [7:0]   stall_mask;
        bit           next_stall;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  = 0;
            hold_done  = 1'b0;
            mode       = 0;
            mode_left  = 0;
            stall_mask = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_replies++;
                if (expected_replies.size() == 0)
                begin
                    $error("result transfer with no command pending: %s %h %0d %0d",
                           "next_hop/status/total", next_hop, status, route_total);
                    err_count++;
                end
                else
                begin
                    exp_rep = expected_replies.pop_front();
                    if (next_hop !== exp_rep.next_hop)
                    begin
                        $error("next_hop mismatch: expected %h, actual %h",
                               exp_rep.next_hop, next_hop);
                        err_count++;
                    end
                    if (status !== exp_rep.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_rep.status, status);
                        err_count++;
                    end
                    if (route_total !== exp_rep.total)
                    begin
                        $error("route_total mismatch: expected %0d, actual %0d",
                               exp_rep.total, route_total);
                        err_count++;
                    end
                end
            end

            // one long hold-off so the engine backs up into its input
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && n_replies >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end

            // stall mode: none, random, or a rotating mask
            if (mode_left > 0)
                mode_left--;
            else
            begin
                mode       = $urandom_range(0, 2);
                mode_left  = $urandom_range(30, 300);
                stall_mask = 8'($urandom);
            end
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            case (mode)
                0:       next_stall = 1'b0;
                1:       next_stall = ($urandom_range(0, 2) == 0);
                default: next_stall = stall_mask[0];
            endcase
            out_stall <= (hold_left > 0) || next_stall;
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_replies.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        route_cmd_t c;
        cmd_mix_t   mix;
        int         n_rand;
        int         seg_left;
        for (int i = 0; i < 8; i++)
            cmd_hits[i] = 0;
        for (int i = 0; i < DEST_POOL_SZ; i++)
            dest_pool[i] = $urandom;
        dest_pool[0] = '0;
        dest_pool[1] = '1;
        // a few neighbors are destinations too, so direct routes get pruned
        for (int i = 0; i < NBR_POOL_SZ; i++)
            nbr_pool[i] = (i < 4) ? dest_pool[i + 2] : $urandom;

        // Directed: empty table, extremes, replacement rules, unused codes
        pending_cmds.push_back('{CMD_LOOKUP,        32'h0,        32'h0,        8'd0});
        pending_cmds.push_back('{CMD_DROP_INDIRECT, 32'h0,        32'h0,        8'd0});
        pending_cmds.push_back('{CMD_DROP_ALL,      32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255});
        pending_cmds.push_back('{CMD_ADD,           32'h0,        32'hFFFFFFFF, 8'd255});
        pending_cmds.push_back('{CMD_ADD,           32'hFFFFFFFF, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_ADD,           32'h0,        32'h5,        8'd255});
        pending_cmds.push_back('{CMD_ADD,           32'h0,        32'h6,        8'd254});
        pending_cmds.push_back('{CMD_ADD_DIRECT,    32'h12345678, 32'hDEADBEEF, 8'd77});
        pending_cmds.push_back('{CMD_ADD_DIRECT,    32'h12345678, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_ADD,           32'hA5A5A5A5, 32'h12345678, 8'd3});
        pending_cmds.push_back('{CMD_ADD,           32'h5A5A5A5A, 32'h5A5A5A5A, 8'd7});
        pending_cmds.push_back('{CMD_ADD,           32'h5A5A5A5A, 32'h12345678, 8'd0});
        pending_cmds.push_back('{CMD_LOOKUP,        32'h0,        32'hFFFFFFFF, 8'd255});
        pending_cmds.push_back('{CMD_LOOKUP,        32'hFFFFFFFF, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_LOOKUP,        32'h12345678, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_LOOKUP,        32'h0BADF00D, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_W'(5),         32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255});
        pending_cmds.push_back('{CMD_W'(6),         32'h0,        32'h0,        8'd0});
        pending_cmds.push_back('{CMD_W'(7),         32'hA5A5A5A5, 32'h5A5A5A5A, 8'd129});
        pending_cmds.push_back('{CMD_DROP_INDIRECT, 32'h0,        32'h12345678, 8'd0});
        pending_cmds.push_back('{CMD_DROP_INDIRECT, 32'h0,        32'h5A5A5A5A, 8'd0});
        pending_cmds.push_back('{CMD_LOOKUP,        32'hA5A5A5A5, 32'h0,        8'd0});
        pending_cmds.push_back('{CMD_DROP_ALL,      32'h0,        32'h12345678, 8'd0});
        pending_cmds.push_back('{CMD_DROP_ALL,      32'h0,        32'h6,        8'd0});
        pending_cmds.push_back('{CMD_LOOKUP,        32'h12345678, 32'h0,        8'd0});

        // Random: a long fill phase first so the table overflows, then mixes
        n_rand   = 0;
        mix      = MIX_FILL;
        seg_left = 220;
        while (n_rand < RANDOM_CMDS)
        begin
            if (seg_left == 0)
            begin
                mix      = cmd_mix_t'($urandom_range(0, 2));
                seg_left = $urandom_range(40, 160);
            end
            seg_left--;
            c = make_route_cmd(mix);
            pending_cmds.push_back(c);
            n_rand++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0 || in_valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_replies.size() > 0)
        begin
            $error("%0d expected results never arrived", expected_replies.size());
            err_count++;
        end
        $display("Run: %0d commands (%0d add, %0d direct, %0d lookup, %0d prune, %0d unused code)",
                 n_sent, cmd_hits[CMD_ADD], cmd_hits[CMD_ADD_DIRECT], cmd_hits[CMD_LOOKUP],
                 cmd_hits[CMD_DROP_INDIRECT] + cmd_hits[CMD_DROP_ALL],
                 n_sent - cmd_hits[CMD_ADD] - cmd_hits[CMD_ADD_DIRECT]
                 - cmd_hits[CMD_LOOKUP] - cmd_hits[CMD_DROP_INDIRECT]
                 - cmd_hits[CMD_DROP_ALL]);
        $display("Table peaked at %0d routes, %0d adds dropped when full, %0d lookup misses",
                 peak_total, n_full, n_miss);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hdl/rte_pkg.sv
hdl/rte_ram.sv
hdl/rte_cmp.sv
hdl/route_table_engine.sv
tb/tb_route_table_engine.sv
